@@ hdl/vmbc_pkg.sv @@
// ----------------------------------------------------------------------------
// vmbc_pkg
// Shared types and constants of the branch/call unit.
// ----------------------------------------------------------------------------
package vmbc_pkg;

  localparam int unsigned StackDepthDefault = 16;
  localparam int unsigned LimitW = 5;
  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  typedef enum logic [2:0] {
    FUNC_NOP   = 3'd0,
    FUNC_END   = 3'd1,
    FUNC_BR    = 3'd2,
    FUNC_BCOND = 3'd3,
    FUNC_CALL  = 3'd4,
    FUNC_RET   = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    COND_NE = 3'd0,
    COND_LT = 3'd1,
    COND_LE = 3'd2,
    COND_EQ = 3'd3,
    COND_GE = 3'd4,
    COND_GT = 3'd5
  } cond_e;

  typedef enum logic [2:0] {
    DT_S8  = 3'd0,
    DT_S16 = 3'd1,
    DT_S32 = 3'd2,
    DT_S64 = 3'd3,
    DT_F32 = 3'd4,
    DT_F64 = 3'd5
  } dtype_e;

  typedef enum logic [1:0] {
    EXIT_CONT  = 2'd0,
    EXIT_END   = 2'd1,
    EXIT_OVER  = 2'd2,
    EXIT_UNDER = 2'd3
  } exit_e;

  // compare flags handed from the comparator to the control stage
  typedef struct packed {
    logic lt;
    logic eq;
    logic unord;
  } cmp_t;

endpackage

@@ hdl/vmbc_compare.sv @@
// ----------------------------------------------------------------------------
// vmbc_compare
// Typed less-than / equal / unordered flags for integer and IEEE operands.
// ----------------------------------------------------------------------------
module vmbc_compare (
  input  logic [2:0]      dtype_i,
  input  logic [63:0]     a_i,
  input  logic [63:0]     b_i,
  output vmbc_pkg::cmp_t  cmp_o
);

  logic [63:0] ka, kb;
  logic        fa_nan, fb_nan, fa_zero, fb_zero, fsa, fsb;
  logic [62:0] fma, fmb;
  logic        mag_lt, mag_eq;

  always_comb begin
    ka = '0;
    kb = '0;
    fa_nan = 1'b0;
    fb_nan = 1'b0;
    fma = '0;
    fmb = '0;
    fsa = 1'b0;
    fsb = 1'b0;
    case (dtype_i)
      vmbc_pkg::DT_S8: begin
        ka = {56'd0, a_i[7] ^ 1'b1, a_i[6:0]};
        kb = {56'd0, b_i[7] ^ 1'b1, b_i[6:0]};
      end
      vmbc_pkg::DT_S16: begin
        ka = {48'd0, ~a_i[15], a_i[14:0]};
        kb = {48'd0, ~b_i[15], b_i[14:0]};
      end
      vmbc_pkg::DT_S32: begin
        ka = {32'd0, ~a_i[31], a_i[30:0]};
        kb = {32'd0, ~b_i[31], b_i[30:0]};
      end
      vmbc_pkg::DT_S64: begin
        ka = {~a_i[63], a_i[62:0]};
        kb = {~b_i[63], b_i[62:0]};
      end
      vmbc_pkg::DT_F32: begin
        fsa = a_i[31];
        fsb = b_i[31];
        fma = {32'd0, a_i[30:0]};
        fmb = {32'd0, b_i[30:0]};
        fa_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != '0);
        fb_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != '0);
      end
      default: begin
        fsa = a_i[63];
        fsb = b_i[63];
        fma = a_i[62:0];
        fmb = b_i[62:0];
        fa_nan = (a_i[62:52] == 11'h7FF) && (a_i[51:0] != '0);
        fb_nan = (b_i[62:52] == 11'h7FF) && (b_i[51:0] != '0);
      end
    endcase
  end

  assign fa_zero = (fma == '0);
  assign fb_zero = (fmb == '0);
  assign mag_lt  = fma < fmb;
  assign mag_eq  = fma == fmb;

  always_comb begin
    cmp_o = '0;
    if (dtype_i == vmbc_pkg::DT_F32 || dtype_i == vmbc_pkg::DT_F64) begin
      cmp_o.unord = fa_nan | fb_nan;
      // +0 and -0 compare equal
      if (fa_zero && fb_zero) begin
        cmp_o.eq = 1'b1;
      end else if (fsa != fsb) begin
        cmp_o.lt = fsa;
      end else begin
        cmp_o.eq = mag_eq;
        cmp_o.lt = fsa ? (!mag_lt && !mag_eq) : mag_lt;
      end
    end else begin
      cmp_o.lt = ka < kb;
      cmp_o.eq = ka == kb;
    end
  end

endmodule

@@ hdl/vmbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// vmbc_ctrl
// Next-address selection and return stack.
// ----------------------------------------------------------------------------
module vmbc_ctrl #(
  parameter int unsigned STACK_DEPTH = vmbc_pkg::StackDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [vmbc_pkg::LimitW-1:0] limit_i,
  input  logic [2:0]                 func_i,
  input  logic [2:0]                 cond_i,
  input  logic [2:0]                 dtype_i,
  input  vmbc_pkg::cmp_t             cmp_i,
  input  logic [31:0]                addr_i,
  input  logic [31:0]                off_i,
  input  logic [31:0]                target_i,
  output logic [31:0]                next_o,
  output logic                       taken_o,
  output logic [1:0]                 code_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [31:0]     stack_q [STACK_DEPTH];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW:0]   lim_eff;
  logic [IdxW-1:0] top_idx, push_idx;
  logic            hold, push;

  always_comb begin
    if ({{(CntW+1){1'b0}}, limit_i} > (CntW+1+vmbc_pkg::LimitW)'(STACK_DEPTH))
      lim_eff = (CntW+1)'(STACK_DEPTH);
    else
      lim_eff = (CntW+1)'(limit_i);
  end

  always_comb begin
    logic l, e, u;
    l = cmp_i.lt;
    e = cmp_i.eq;
    u = cmp_i.unord;
    hold = 1'b0;
    case (cond_i)
      vmbc_pkg::COND_NE: hold = u | !e;
      vmbc_pkg::COND_LT: hold = !u & l;
      vmbc_pkg::COND_LE: hold = !u & (l | e);
      vmbc_pkg::COND_EQ: hold = !u & e;
      vmbc_pkg::COND_GE: hold = !u & !l;
      vmbc_pkg::COND_GT: hold = !u & !l & !e;
      default:           hold = 1'b0;
    endcase
    if (dtype_i == 3'd6 || dtype_i == 3'd7) hold = 1'b0;
  end

  assign push_idx = IdxW'(cnt_q);
  assign top_idx  = IdxW'(cnt_q - CntW'(1));

  always_comb begin
    next_o  = addr_i + 32'd1;
    taken_o = 1'b0;
    code_o  = vmbc_pkg::EXIT_CONT;
    cnt_d   = cnt_q;
    push    = 1'b0;
    case (func_i)
      vmbc_pkg::FUNC_END: begin
        next_o = addr_i;
        code_o = vmbc_pkg::EXIT_END;
      end
      vmbc_pkg::FUNC_BR: begin
        next_o  = addr_i + 32'd1 + off_i;
        taken_o = 1'b1;
      end
      vmbc_pkg::FUNC_BCOND: begin
        if (hold) begin
          next_o  = addr_i + off_i;
          taken_o = 1'b1;
        end
      end
      vmbc_pkg::FUNC_CALL: begin
        if ({1'b0, cnt_q} < lim_eff) begin
          push    = 1'b1;
          cnt_d   = cnt_q + CntW'(1);
          next_o  = target_i;
          taken_o = 1'b1;
        end else begin
          next_o = addr_i;
          code_o = vmbc_pkg::EXIT_OVER;
        end
      end
      vmbc_pkg::FUNC_RET: begin
        if (cnt_q != '0) begin
          cnt_d   = cnt_q - CntW'(1);
          next_o  = stack_q[top_idx];
          taken_o = 1'b1;
        end else begin
          next_o = addr_i;
          code_o = vmbc_pkg::EXIT_UNDER;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (fire_i) cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && push) stack_q[push_idx] <= addr_i;
  end

endmodule

@@ hdl/vm_branch_call_unit.sv @@
// ----------------------------------------------------------------------------
// vm_branch_call_unit
// Flow-control unit: branches, typed conditional branches, call and return.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid_i / in_ready_o
// out     | output    | out_valid_o / out_ready_i
// cfg     | input     | cfg_we_i (stack_limit, no wait)
//
// One request per cycle while the result is not stalled: input register, compare
// and stack update, result register. Reset clears valids, stack count and sets
// stack_limit to 16. The input stage advances whenever the result register
// is empty or being drained; a stalled result holds both stages.
module vm_branch_call_unit #(
  parameter int unsigned STACK_DEPTH = vmbc_pkg::StackDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [2:0]  cond_i,
  input  logic [2:0]  dtype_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic [31:0] word_addr_i,
  input  logic signed [31:0] branch_offset_i,
  input  logic [31:0] call_target_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_addr_o,
  output logic        taken_o,
  output logic [1:0]  exit_code_o
);

  logic [4:0]  limit_q;
  logic        s1_valid_q, out_valid_q;
  logic [2:0]  func_q, cond_q, dtype_q;
  logic [63:0] a_q, b_q;
  logic [31:0] addr_q, off_q, target_q;
  logic [31:0] next_d, next_q;
  logic        taken_d, taken_q;
  logic [1:0]  code_d, code_q;
  logic        s2_free, s1_adv;
  vmbc_pkg::cmp_t cmp;

  assign s2_free    = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= vmbc_pkg::LimitReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s2_free) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q   <= func_i;
      cond_q   <= cond_i;
      dtype_q  <= dtype_i;
      a_q      <= operand_a_i;
      b_q      <= operand_b_i;
      addr_q   <= word_addr_i;
      off_q    <= branch_offset_i;
      target_q <= call_target_i;
    end
    if (s1_adv) begin
      next_q  <= next_d;
      taken_q <= taken_d;
      code_q  <= code_d;
    end
  end

  vmbc_compare u_cmp (
    .dtype_i (dtype_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .cmp_o   (cmp)
  );

  vmbc_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_adv),
    .limit_i  (limit_q),
    .func_i   (func_q),
    .cond_i   (cond_q),
    .dtype_i  (dtype_q),
    .cmp_i    (cmp),
    .addr_i   (addr_q),
    .off_i    (off_q),
    .target_i (target_q),
    .next_o   (next_d),
    .taken_o  (taken_d),
    .code_o   (code_d)
  );

  assign out_valid_o = out_valid_q;
  assign next_addr_o = next_q;
  assign taken_o     = taken_q;
  assign exit_code_o = code_q;

`ifndef ASSERT_OFF
  a_flag_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exit_code_o != vmbc_pkg::EXIT_CONT |-> !taken_o)
    else $error("flagged result marked taken");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_addr_o))
    else $error("stalled result changed");
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |=> s1_valid_q && $stable(addr_q))
    else $error("input stage lost request");
`endif

endmodule

@@ test/tb_vm_branch_call_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vm_branch_call_unit
// Self-checking bench: a directed table, then random instruction mixes
// under several stack limits, checked against a local flow-control predictor.
// ----------------------------------------------------------------------------
module tb_vm_branch_call_unit;

  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;
  localparam logic [2:0] COND_SPARE   = 3'd6;
  localparam logic [2:0] DT_SPARE     = 3'd7;
  localparam int unsigned DEPTH = vmbc_pkg::StackDepthDefault;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [2:0]  func;
    logic [2:0]  cond;
    logic [2:0]  dtype;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [31:0] addr;
    logic [31:0] offset;
    logic [31:0] target;
    bit          typed;   // expected result given in the table row
    logic [31:0] exp_next;
    logic        exp_taken;
    vmbc_pkg::exit_e exp_code;
  } instr_t;

  typedef struct {
    logic [31:0] next;
    logic        taken;
    vmbc_pkg::exit_e code;
  } flow_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = '0;
  logic [2:0]  cond_i = '0;
  logic [2:0]  dtype_i = '0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic [31:0] word_addr_i = '0;
  logic signed [31:0] branch_offset_i = '0;
  logic [31:0] call_target_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] next_addr_o;
  logic        taken_o;
  logic [1:0]  exit_code_o;

  always #5 clk_i = ~clk_i;

  vm_branch_call_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .func_i, .cond_i, .dtype_i,
    .operand_a_i, .operand_b_i, .word_addr_i, .branch_offset_i, .call_target_i,
    .out_valid_o, .out_ready_i, .next_addr_o, .taken_o, .exit_code_o
  );

  // predictor state
  logic [31:0] ret_stack [DEPTH];
  int unsigned ret_count = 0;
  logic [4:0]  limit_reg = vmbc_pkg::LimitReset;
  flow_t       flow_q[$];

  int  errors = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  stall_cyc = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // {lt, eq, unord} of two IEEE values
  function automatic logic [2:0] fp_flags(logic [63:0] a, logic [63:0] b, bit dbl);
    logic [63:0] x, y, sgn, mask, kx, ky;
    bit na, nb, za, zb;
    if (dbl) begin
      x = a; y = b; mask = '1; sgn = 64'h8000_0000_0000_0000;
      na = (a[62:52] == '1) && (a[51:0] != 0);
      nb = (b[62:52] == '1) && (b[51:0] != 0);
      za = a[62:0] == 0; zb = b[62:0] == 0;
    end else begin
      x = {32'b0, a[31:0]}; y = {32'b0, b[31:0]};
      mask = 64'hFFFF_FFFF; sgn = 64'h8000_0000;
      na = (a[30:23] == '1) && (a[22:0] != 0);
      nb = (b[30:23] == '1) && (b[22:0] != 0);
      za = a[30:0] == 0; zb = b[30:0] == 0;
    end
    if (na || nb) return 3'b001;
    if (za && zb) return 3'b010;
    kx = ((x & sgn) != 0) ? (~x & mask) : (x | sgn);
    ky = ((y & sgn) != 0) ? (~y & mask) : (y | sgn);
    return {kx < ky, kx == ky, 1'b0};
  endfunction

  function automatic bit cond_holds(logic [2:0] cond, logic [2:0] dtype,
                                    logic [63:0] a, logic [63:0] b);
    logic [63:0] mask, sgn;
    logic [2:0] f;
    int w;
    bit lt, eq, un;
    case (dtype)
      vmbc_pkg::DT_S8, vmbc_pkg::DT_S16, vmbc_pkg::DT_S32, vmbc_pkg::DT_S64: begin
        w = (dtype == vmbc_pkg::DT_S8) ? 8 : (dtype == vmbc_pkg::DT_S16) ? 16 :
            (dtype == vmbc_pkg::DT_S32) ? 32 : 64;
        mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
        sgn = 64'd1 << (w - 1);
        lt = ((a & mask) ^ sgn) < ((b & mask) ^ sgn);
        eq = (a & mask) == (b & mask);
        un = 1'b0;
      end
      vmbc_pkg::DT_F32, vmbc_pkg::DT_F64: begin
        f = fp_flags(a, b, dtype == vmbc_pkg::DT_F64);
        {lt, eq, un} = f;
      end
      default: return 1'b0;
    endcase
    case (cond)
      vmbc_pkg::COND_NE: return !eq;
      vmbc_pkg::COND_LT: return lt;
      vmbc_pkg::COND_LE: return lt || eq;
      vmbc_pkg::COND_EQ: return eq;
      vmbc_pkg::COND_GE: return !lt && !un;
      vmbc_pkg::COND_GT: return !lt && !eq && !un;
      default: return 1'b0;
    endcase
  endfunction

  function automatic flow_t next_flow(instr_t it);
    flow_t r;
    int unsigned lim;
    r.next = it.addr + 1; r.taken = 1'b0; r.code = vmbc_pkg::EXIT_CONT;
    case (it.func)
      vmbc_pkg::FUNC_END: begin r.next = it.addr; r.code = vmbc_pkg::EXIT_END; end
      vmbc_pkg::FUNC_BR: begin r.next = it.addr + 1 + it.offset; r.taken = 1'b1; end
      vmbc_pkg::FUNC_BCOND: if (cond_holds(it.cond, it.dtype, it.op_a, it.op_b)) begin
        r.next = it.addr + it.offset; r.taken = 1'b1;
      end
      vmbc_pkg::FUNC_CALL: begin
        lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
        if (ret_count < lim) begin
          ret_stack[ret_count] = it.addr;
          ret_count++;
          r.next = it.target; r.taken = 1'b1;
        end else begin
          r.next = it.addr; r.code = vmbc_pkg::EXIT_OVER;
        end
      end
      vmbc_pkg::FUNC_RET: begin
        if (ret_count > 0) begin
          ret_count--;
          r.next = ret_stack[ret_count]; r.taken = 1'b1;
        end else begin
          r.next = it.addr; r.code = vmbc_pkg::EXIT_UNDER;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_instr(instr_t it);
    flow_t f;
    int k;
    if (!calm && $urandom_range(99) < 30) begin
      k = $urandom_range(4, 1);
      in_valid_i <= 1'b0;
      repeat (k) @(posedge clk_i);
    end
    func_i <= it.func; cond_i <= it.cond; dtype_i <= it.dtype;
    operand_a_i <= it.op_a; operand_b_i <= it.op_b;
    word_addr_i <= it.addr; branch_offset_i <= it.offset; call_target_i <= it.target;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    f = next_flow(it);
    if (it.typed) begin
      f.next = it.exp_next; f.taken = it.exp_taken; f.code = it.exp_code;
    end
    flow_q.push_back(f);
  endtask

  // wait for every result, let the pipe empty, optionally write the limit
  task automatic drain(input bit write, input logic [4:0] lim);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (flow_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (write) begin
      cfg_we_i <= 1'b1; cfg_wdata_i <= lim;
      @(posedge clk_i);
      limit_reg = lim;
      cfg_we_i <= 1'b0;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] special_val(logic [2:0] dtype);
    logic [63:0] v;
    v = rand64();
    case (dtype)
      vmbc_pkg::DT_F32: case ($urandom_range(6))
        0: v[31:0] = 32'h7FC0_0000;
        1: v[31:0] = 32'hFF80_0000;
        2: v[31:0] = 32'h7F80_0000;
        3: v[31:0] = 32'h0000_0000;
        4: v[31:0] = 32'h8000_0000;
        5: v[31:0] = 32'h7F80_0001;
        default: v[31:0] = 32'h3F80_0000;
      endcase
      vmbc_pkg::DT_F64: case ($urandom_range(6))
        0: v = 64'h7FF8_0000_0000_0000;
        1: v = 64'hFFF0_0000_0000_0000;
        2: v = 64'h7FF0_0000_0000_0000;
        3: v = 64'h0;
        4: v = 64'h8000_0000_0000_0000;
        5: v = 64'hFFF0_0000_0000_0001;
        default: v = 64'h3FF0_0000_0000_0000;
      endcase
      default: case ($urandom_range(3))
        0: v = '0;
        1: v = '1;
        2: v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(7));
        default: v = {$urandom, 32'h0} >> $urandom_range(63);
      endcase
    endcase
    return v;
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    int p;
    it.typed = 1'b0; it.exp_next = '0; it.exp_taken = 1'b0;
    it.exp_code = vmbc_pkg::EXIT_CONT;
    p = $urandom_range(99);
    if (p < 25) it.func = vmbc_pkg::FUNC_CALL;
    else if (p < 50) it.func = vmbc_pkg::FUNC_RET;
    else if (p < 80) it.func = vmbc_pkg::FUNC_BCOND;
    else if (p < 88) it.func = vmbc_pkg::FUNC_BR;
    else if (p < 94) it.func = vmbc_pkg::FUNC_NOP;
    else if (p < 97) it.func = vmbc_pkg::FUNC_END;
    else it.func = $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
    it.cond = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    it.dtype = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    case ($urandom_range(3))
      0: begin it.op_a = rand64(); it.op_b = rand64(); end
      1: begin it.op_a = rand64(); it.op_b = it.op_a ^ (rand64() & ~64'hFF); end
      default: begin it.op_a = special_val(it.dtype); it.op_b = special_val(it.dtype); end
    endcase
    it.addr = $urandom;
    case ($urandom_range(3))
      0: it.offset = 32'h8000_0000;
      1: it.offset = 32'h7FFF_FFFF;
      default: it.offset = $urandom;
    endcase
    it.target = $urandom;
    return it;
  endfunction

  function automatic instr_t mk(logic [2:0] func, logic [2:0] cond, logic [2:0] dtype,
                                logic [63:0] a, logic [63:0] b, logic [31:0] addr,
                                logic [31:0] offset, logic [31:0] target);
    instr_t it;
    it.func = func; it.cond = cond; it.dtype = dtype; it.op_a = a; it.op_b = b;
    it.addr = addr; it.offset = offset; it.target = target;
    it.typed = 1'b0; it.exp_next = '0; it.exp_taken = 1'b0;
    it.exp_code = vmbc_pkg::EXIT_CONT;
    return it;
  endfunction

  function automatic instr_t typed(instr_t it, logic [31:0] nxt, logic tk,
                                   vmbc_pkg::exit_e code);
    it.typed = 1'b1; it.exp_next = nxt; it.exp_taken = tk; it.exp_code = code;
    return it;
  endfunction

  // result side: check, then pick ready for the next cycle
  always @(posedge clk_i) begin
    flow_t w;
    if (out_valid_o && out_ready_i) begin
      if (flow_q.size() == 0) begin
        report("unexpected result", next_addr_o, 32'h0);
      end else begin
        w = flow_q.pop_front();
        if (next_addr_o !== w.next) report("next_addr", next_addr_o, w.next);
        if (taken_o !== w.taken) report("taken", {31'b0, taken_o}, {31'b0, w.taken});
        if (exit_code_o !== w.code) report("exit_code", {30'b0, exit_code_o}, {30'b0, w.code});
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      stall_cyc <= 0;
    else
      stall_cyc <= stall_cyc + 1;
    if (stall_cyc >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    instr_t dir[$];
    logic [4:0] limits[7];
    limits = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd16};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir.push_back(typed(mk(vmbc_pkg::FUNC_RET, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                           0, 0, 32'd123, 0, 0),
                        32'd123, 1'b0, vmbc_pkg::EXIT_UNDER));
    dir.push_back(typed(mk(vmbc_pkg::FUNC_NOP, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                           0, 0, 32'hFFFF_FFFF, 0, 0),
                        32'h0, 1'b0, vmbc_pkg::EXIT_CONT));
    dir.push_back(typed(mk(vmbc_pkg::FUNC_END, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                           '1, '1, 32'd5, 32'd9, 0),
                        32'd5, 1'b0, vmbc_pkg::EXIT_END));
    dir.push_back(typed(mk(vmbc_pkg::FUNC_BR, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                           0, 0, 32'h0, 32'hFFFF_FFFF, 0),
                        32'h0, 1'b1, vmbc_pkg::EXIT_CONT));
    dir.push_back(mk(vmbc_pkg::FUNC_BR, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                     0, 0, 32'h10, 32'h8000_0000, 0));
    for (int c = vmbc_pkg::COND_NE; c <= vmbc_pkg::COND_GT; c++)
      dir.push_back(mk(vmbc_pkg::FUNC_BCOND, 3'(c), vmbc_pkg::DT_S8,
                       64'hABCD_0000_0000_0080, 64'h1234_0000_0000_007F,
                       32'h100, 32'h7FFF_FFFF, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_LT, vmbc_pkg::DT_S16,
                     64'h8000, 64'hFFFF_0000_0000_7FFF, 7, 3, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_GT, vmbc_pkg::DT_S32,
                     64'h7FFF_FFFF, 64'h8000_0000, 7, 3, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_LE, vmbc_pkg::DT_S64,
                     64'h8000_0000_0000_0000, '1, 7, 3, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_NE, vmbc_pkg::DT_F32,
                     64'h7FC0_0000, 64'h7FC0_0000, 7, 3, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_EQ, vmbc_pkg::DT_F32,
                     64'h7FC0_0000, 64'h7FC0_0000, 7, 3, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_EQ, vmbc_pkg::DT_F64,
                     64'h8000_0000_0000_0000, 0, 7, 3, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_GE, vmbc_pkg::DT_F64,
                     64'h7FF8_0000_0000_0001, 0, 7, 3, 0));
    dir.push_back(mk(FUNC_SPARE_A, vmbc_pkg::COND_EQ, vmbc_pkg::DT_S8,
                     0, 0, 32'd40, 32'd4, 32'd4));
    dir.push_back(mk(FUNC_SPARE_B, vmbc_pkg::COND_EQ, vmbc_pkg::DT_S8,
                     0, 0, 32'd41, 32'd4, 32'd4));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, COND_SPARE, vmbc_pkg::DT_S8,
                     0, 0, 32'd50, 32'd4, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_BCOND, vmbc_pkg::COND_EQ, DT_SPARE,
                     0, 0, 32'd51, 32'd4, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_CALL, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                     0, 0, 32'hFFFF_FFFF, 0, 32'h0));
    dir.push_back(mk(vmbc_pkg::FUNC_CALL, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                     0, 0, 32'h0, 0, 32'hFFFF_FFFF));
    dir.push_back(mk(vmbc_pkg::FUNC_RET, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                     0, 0, 32'd1, 0, 0));
    dir.push_back(mk(vmbc_pkg::FUNC_RET, vmbc_pkg::COND_NE, vmbc_pkg::DT_S8,
                     0, 0, 32'd2, 0, 0));
    foreach (dir[i]) send_instr(dir[i]);

    for (int p = 0; p < 7; p++) begin
      drain(1'b1, limits[p]);
      calm = (p == 4);
      for (int n = 0; n < 250; n++) begin
        if (p == 2 && n == 50) hold_req = 1'b1;
        if (p == 3 && n == 100) drain(1'b0, '0);
        send_instr(rand_instr());
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (flow_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/vmbc_pkg.sv
hdl/vmbc_compare.sv
hdl/vmbc_ctrl.sv
hdl/vm_branch_call_unit.sv
test/tb_vm_branch_call_unit.sv
